[design/bft_pkg.sv]
// bidirectional flow table: shared types, constants and codes
// no dependencies
package bft_pkg;

    localparam int unsigned BUCKETS_DEF    = 1024;
    localparam int unsigned WAYS_DEF       = 4;
    localparam int unsigned MULTIPLIER_DEF = 31;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned PROTO_W  = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ENTRY_W  = 12;
    localparam int unsigned BKT_W    = 10;
    localparam int unsigned HASH_W   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP   = 2'd0,
        OP_REGISTER = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_SPARE    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic               address_family;
        logic [PROTO_W-1:0] protocol;
        logic [ADDR_W-1:0]  ip1_hi;
        logic [ADDR_W-1:0]  ip1_lo;
        logic [ADDR_W-1:0]  ip2_hi;
        logic [ADDR_W-1:0]  ip2_lo;
        logic [PORT_W-1:0]  port_a;
        logic [PORT_W-1:0]  port_b;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry_index;
        logic [BKT_W-1:0]    bucket_index;
    } t_rsp;

    // hash engine control
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_hash_ctl;

endpackage

[design/bft_if.sv]
// valid/ready channel carrying one packed payload
// depends on nothing; payload type is a parameter
interface bft_if #(
    parameter type T = logic
) (
    input logic i_clk
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/bft_hash.sv]
// symmetric byte hash: forward and reverse multiply-add, two bytes a cycle each,
// then reduction of the summed hash to a bucket by reciprocal multiplication
// depends on bft_pkg
module bft_hash #(
    parameter int unsigned BUCKETS    = bft_pkg::BUCKETS_DEF,
    parameter int unsigned MULTIPLIER = bft_pkg::MULTIPLIER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  bft_pkg::t_req              i_req,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_bkt
);
    import bft_pkg::*;

    // byte stream: up to 16+16+2+2 bytes; two bytes per cycle
    localparam int unsigned NBYTES = 36;
    localparam int unsigned CNT_W  = $clog2(NBYTES + 1);
    localparam int unsigned BKT_AW = $clog2(BUCKETS);
    // floor(2^32 / BUCKETS); quotient estimate is short by at most one
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / 64'(BUCKETS));

    logic [NBYTES*8-1:0] r_fwd, n_fwd;
    logic [NBYTES*8-1:0] r_rev, n_rev;
    logic [CNT_W-1:0]    r_left, n_left;
    logic [HASH_W-1:0]   r_hf, n_hf, r_hr, n_hr;
    logic                r_busy, n_busy, r_fin, n_fin;
    logic                r_s1, r_s2, r_s3;
    logic [HASH_W-1:0]   r_x, r_q, r_rm;

    logic [NBYTES*8-1:0] w_fwd, w_rev;
    logic [CNT_W-1:0]    w_len;
    logic [HASH_W-1:0]   w_hf1, w_hr1, w_hf2, w_hr2;
    logic [2*HASH_W-1:0] w_prod;
    logic [HASH_W-1:0]   w_qb;
    logic [HASH_W-1:0]   w_rm;

    // bytes packed to the top of the shift word, first byte highest
    always_comb begin
        logic [15:0] pa_n, pb_n;
        logic [4:0]  pa_len, pb_len;
        logic [255:0] af, ar;
        logic [8:0]  alen;
        pa_n   = i_req.port_a;
        pb_n   = i_req.port_b;
        pa_len = (pa_n != '0) ? 5'd2 : 5'd0;
        pb_len = (pb_n != '0) ? 5'd2 : 5'd0;
        if (i_req.address_family) begin
            af   = {i_req.ip1_hi, i_req.ip1_lo, i_req.ip2_hi, i_req.ip2_lo};
            ar   = {i_req.ip2_hi, i_req.ip2_lo, i_req.ip1_hi, i_req.ip1_lo};
            alen = 9'd32;
        end else begin
            af   = {i_req.ip1_lo[31:0], i_req.ip2_lo[31:0], 192'd0};
            ar   = {i_req.ip2_lo[31:0], i_req.ip1_lo[31:0], 192'd0};
            alen = 9'd8;
        end
        w_fwd = {af, 32'd0};
        w_rev = {ar, 32'd0};
        // ports sit right after the address bytes
        w_fwd = w_fwd | ((NBYTES*8)'({pa_n, pb_n}) << ((NBYTES - 32'(alen) - 4) * 8));
        w_rev = w_rev | ((NBYTES*8)'({pb_n, pa_n}) << ((NBYTES - 32'(alen) - 4) * 8));
        if (pa_n == '0 && pb_n != '0) begin
            w_fwd = {af, 32'd0} | ((NBYTES*8)'({pb_n, 16'd0})
                    << ((NBYTES - 32'(alen) - 4) * 8));
            w_rev = {ar, 32'd0} | ((NBYTES*8)'({pb_n, 16'd0})
                    << ((NBYTES - 32'(alen) - 4) * 8));
        end else if (pa_n != '0 && pb_n == '0) begin
            w_fwd = {af, 32'd0} | ((NBYTES*8)'({pa_n, 16'd0})
                    << ((NBYTES - 32'(alen) - 4) * 8));
            w_rev = {ar, 32'd0} | ((NBYTES*8)'({pa_n, 16'd0})
                    << ((NBYTES - 32'(alen) - 4) * 8));
        end
        w_len = CNT_W'(alen) + CNT_W'(pa_len) + CNT_W'(pb_len);
    end

    // multiply-add, applied twice per cycle per direction
    assign w_hf1 = r_hf * HASH_W'(MULTIPLIER) + HASH_W'(r_fwd[NBYTES*8-1 -: 8]);
    assign w_hr1 = r_hr * HASH_W'(MULTIPLIER) + HASH_W'(r_rev[NBYTES*8-1 -: 8]);
    assign w_hf2 = w_hf1 * HASH_W'(MULTIPLIER) + HASH_W'(r_fwd[NBYTES*8-9 -: 8]);
    assign w_hr2 = w_hr1 * HASH_W'(MULTIPLIER) + HASH_W'(r_rev[NBYTES*8-9 -: 8]);

    // bucket reduction: estimate quotient, subtract, one conditional correction
    assign w_prod = (2*HASH_W)'(r_x) * (2*HASH_W)'(RECIP);
    assign w_qb   = r_q * HASH_W'(BUCKETS);
    assign w_rm   = (r_rm >= HASH_W'(BUCKETS)) ? r_rm - HASH_W'(BUCKETS) : r_rm;

    always_comb begin
        n_fwd  = r_fwd;
        n_rev  = r_rev;
        n_left = r_left;
        n_hf   = r_hf;
        n_hr   = r_hr;
        n_busy = r_busy;
        n_fin  = 1'b0;
        if (i_start) begin
            n_fwd  = w_fwd;
            n_rev  = w_rev;
            n_left = w_len;
            n_hf   = '0;
            n_hr   = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // byte counts are always even
            n_hf   = w_hf2;
            n_hr   = w_hr2;
            n_fwd  = r_fwd << 16;
            n_rev  = r_rev << 16;
            n_left = r_left - CNT_W'(2);
            if (r_left == CNT_W'(2)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_s3   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_s1   <= r_fin;
            r_s2   <= r_s1;
            r_s3   <= r_s2;
        end
        r_fwd  <= n_fwd;
        r_rev  <= n_rev;
        r_left <= n_left;
        r_hf   <= n_hf;
        r_hr   <= n_hr;
        if (r_fin) begin
            r_x <= r_hf + r_hr;
        end
        if (r_s1) begin
            r_q <= w_prod[2*HASH_W-1:HASH_W];
        end
        if (r_s2) begin
            r_rm <= r_x - w_qb;
        end
    end

    assign o_done = r_s3;
    assign o_bkt  = w_rm[BKT_AW-1:0];
endmodule

[design/bft_store.sv]
// entry memory plus bucket fill counts, both with registered reads
// depends on bft_pkg
module bft_store #(
    parameter int unsigned BUCKETS = bft_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS    = bft_pkg::WAYS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [$clog2(BUCKETS)-1:0]            i_fill_addr,
    input  logic                                  i_fill_we,
    input  logic [$clog2(WAYS+1)-1:0]             i_fill_wdata,
    output logic [$clog2(WAYS+1)-1:0]             o_fill,
    input  logic [$clog2(BUCKETS*WAYS)-1:0]       i_ent_addr,
    input  logic                                  i_ent_we,
    input  bft_pkg::t_req                         i_ent_wdata,
    output bft_pkg::t_req                         o_ent
);
    import bft_pkg::*;

    localparam int unsigned FILL_W = $clog2(WAYS + 1);

    // fill counts are zeroed by the sequencer's sweep after reset and on clear
    logic [FILL_W-1:0] m_fill [BUCKETS];
    t_req              m_ent  [BUCKETS*WAYS];
    logic [FILL_W-1:0] r_fill_q;

    // one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (i_fill_we) begin
            m_fill[i_fill_addr] <= i_fill_wdata;
        end
        r_fill_q <= m_fill[i_fill_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            m_ent[i_ent_addr] <= i_ent_wdata;
        end
        o_ent <= m_ent[i_ent_addr];
    end

    assign o_fill = r_fill_q;
endmodule

[design/bidirectional_flow_table_core.sv]
// bidirectional flow table top: sequencer over hash engine and entry store
// depends on bft_pkg, bft_if, bft_hash, bft_store
//
// channel   dir   payload   beat
// i_req     in    t_req     one lookup, register or clear
// o_rsp     out   t_rsp     one result per request
//
// with L hashed bytes (8 to 36), a register or a lookup hashes them, reduces the hash
// to a bucket and reads its fill count; a lookup of a non-empty bucket then scans its ways.
// the byte hash (two bytes a cycle) and the bucket reduction set most of the time.
// clear sweeps every fill count; the same sweep runs after reset.
// one request at a time: i_req.ready is high only while idle.
// a result waits in the output register; the sequencer stalls only if it is still held.
module bidirectional_flow_table_core #(
    parameter int unsigned BUCKETS    = bft_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS       = bft_pkg::WAYS_DEF,
    parameter int unsigned MULTIPLIER = bft_pkg::MULTIPLIER_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    bft_if.sink   i_req,
    bft_if.source o_rsp
);
    import bft_pkg::*;

    localparam int unsigned BKT_AW = $clog2(BUCKETS);
    localparam int unsigned ENT_AW = $clog2(BUCKETS*WAYS);
    localparam int unsigned FILL_W = $clog2(WAYS + 1);
    localparam int unsigned ENT_W  = bft_pkg::ENTRY_W;

    typedef enum logic [7:0] {
        S_SWEEP = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH  = 8'b0000_0100,
        S_FILL  = 8'b0000_1000,
        S_DEC   = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_CMP   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [BKT_AW-1:0]   r_bkt, n_bkt;
    logic [FILL_W-1:0]   r_way, n_way;
    t_rsp                r_rsp, n_rsp;
    t_rsp                r_out, n_out;
    logic                r_vld, n_vld;
    logic                r_clr, n_clr;

    t_hash_ctl           w_hctl;
    logic [BKT_AW-1:0]   w_hbkt;
    logic [FILL_W-1:0]   w_fill;
    t_req                w_ent;
    logic [BKT_AW-1:0]   w_fill_addr;
    logic                w_fill_we;
    logic [FILL_W-1:0]   w_fill_wdata;
    logic [ENT_AW-1:0]   w_ent_addr;
    logic                w_ent_we;
    logic                w_match;

    assign w_hctl.start = (r_state == S_IDLE) && i_req.valid
                          && (t_op'(i_req.data.operation) != OP_CLEAR);
    assign w_hctl.busy  = (r_state == S_HASH);

    bft_hash #(.BUCKETS(BUCKETS), .MULTIPLIER(MULTIPLIER)) u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_hctl.start),
        .i_req  (i_req.data),
        .o_done (w_hctl.done),
        .o_bkt  (w_hbkt)
    );

    bft_store #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fill_addr (w_fill_addr),
        .i_fill_we   (w_fill_we),
        .i_fill_wdata(w_fill_wdata),
        .o_fill      (w_fill),
        .i_ent_addr  (w_ent_addr),
        .i_ent_we    (w_ent_we),
        .i_ent_wdata (r_req),
        .o_ent       (w_ent)
    );

    // bidirectional compare; IPv4 uses the low 32 bits only
    always_comb begin
        logic a11, a22, a12, a21;
        if (r_req.address_family) begin
            a11 = (w_ent.ip1_hi == r_req.ip1_hi) && (w_ent.ip1_lo == r_req.ip1_lo);
            a22 = (w_ent.ip2_hi == r_req.ip2_hi) && (w_ent.ip2_lo == r_req.ip2_lo);
            a12 = (w_ent.ip1_hi == r_req.ip2_hi) && (w_ent.ip1_lo == r_req.ip2_lo);
            a21 = (w_ent.ip2_hi == r_req.ip1_hi) && (w_ent.ip2_lo == r_req.ip1_lo);
        end else begin
            a11 = (w_ent.ip1_lo[31:0] == r_req.ip1_lo[31:0]);
            a22 = (w_ent.ip2_lo[31:0] == r_req.ip2_lo[31:0]);
            a12 = (w_ent.ip1_lo[31:0] == r_req.ip2_lo[31:0]);
            a21 = (w_ent.ip2_lo[31:0] == r_req.ip1_lo[31:0]);
        end
        w_match = (w_ent.address_family == r_req.address_family)
                  && (w_ent.protocol == r_req.protocol)
                  && ((a11 && a22 && w_ent.port_a == r_req.port_a
                       && w_ent.port_b == r_req.port_b)
                   || (a12 && a21 && w_ent.port_a == r_req.port_b
                       && w_ent.port_b == r_req.port_a));
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_bkt        = r_bkt;
        n_way        = r_way;
        n_rsp        = r_rsp;
        n_out        = r_out;
        n_vld        = r_vld;
        n_clr        = r_clr;
        w_fill_addr  = r_bkt;
        w_fill_we    = 1'b0;
        w_fill_wdata = '0;
        w_ent_addr   = ENT_AW'(r_bkt * WAYS + 32'(r_way));
        w_ent_we     = 1'b0;
        if (o_rsp.valid && o_rsp.ready) begin
            n_vld = 1'b0;
        end
        case (r_state)
            S_SWEEP: begin
                w_fill_we = 1'b1;
                n_bkt     = r_bkt + BKT_AW'(1);
                if (32'(r_bkt) == BUCKETS - 1) begin
                    if (r_clr) begin
                        n_clr   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.data;
                    if (t_op'(i_req.data.operation) == OP_CLEAR) begin
                        n_rsp   = '{status: ST_CLEARED, entry_index: '0, bucket_index: '0};
                        n_bkt   = '0;
                        n_clr   = 1'b1;
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (w_hctl.done) begin
                    n_bkt   = w_hbkt;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                n_rsp.bucket_index = BKT_W'(r_bkt);
                n_rsp.entry_index  = '0;
                if (t_op'(r_req.operation) == OP_REGISTER) begin
                    if (32'(w_fill) >= WAYS) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        w_ent_addr   = ENT_AW'(r_bkt * WAYS + 32'(w_fill));
                        w_ent_we     = 1'b1;
                        w_fill_we    = 1'b1;
                        w_fill_wdata = w_fill + FILL_W'(1);
                        n_rsp.status = ST_OK;
                        n_rsp.entry_index = ENT_W'(r_bkt * WAYS + 32'(w_fill));
                    end
                    n_state = S_OUT;
                end else if (w_fill == '0) begin
                    n_rsp.status = ST_MISS;
                    n_state      = S_OUT;
                end else begin
                    n_way   = w_fill - FILL_W'(1);
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_match) begin
                    n_rsp.status      = ST_OK;
                    n_rsp.entry_index = ENT_W'(r_bkt * WAYS + 32'(r_way));
                    n_state           = S_OUT;
                end else if (r_way == '0) begin
                    n_rsp.status = ST_MISS;
                    n_state      = S_OUT;
                end else begin
                    n_way   = r_way - FILL_W'(1);
                    w_ent_addr = ENT_AW'(r_bkt * WAYS + 32'(r_way) - 1);
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                // output register free or emptied this cycle
                if (!r_vld || o_rsp.ready) begin
                    n_out   = r_rsp;
                    n_vld   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_vld   <= 1'b0;
            r_bkt   <= '0;
            r_clr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_bkt   <= n_bkt;
            r_clr   <= n_clr;
        end
        r_req <= n_req;
        r_way <= n_way;
        r_rsp <= n_rsp;
        r_out <= n_out;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_vld;
    assign o_rsp.data  = r_out;

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("ready while busy");
    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ent_we |-> (32'(w_fill) < WAYS))) else $error("write into full bucket");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> $stable(r_out)) else $error("result moved");
endmodule
